@@ src/sidi_pkg.sv @@
// ----------------------------------------------------------------------------
// sidi_pkg: shared types and constants
// Widths, character codes and the pipeline payload of the decimal text unit.
// ----------------------------------------------------------------------------
package sidi_pkg;

  localparam int ValueW        = 32;
  localparam int NumDigits     = 10;
  localparam int BcdW          = 4 * NumDigits;
  localparam int StepsPerStage = 8;
  localparam int NumStages     = ValueW / StepsPerStage;
  localparam int IdxW          = $clog2(NumDigits);
  localparam int CharW         = 8;

  localparam logic [CharW-1:0] CharMinus = 8'd45;
  localparam logic [CharW-1:0] CharZero  = 8'd48;

  typedef logic [3:0] digit_t;

  typedef struct packed {
    logic              neg;
    logic [ValueW-1:0] bin;
    logic [BcdW-1:0]   bcd;
  } dab_t;

endpackage

@@ src/sidi_if.sv @@
// ----------------------------------------------------------------------------
// sidi_if: stream channels
// Input value channel and output character channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sidi_in_if;
  logic                valid;
  logic                ready;
  logic signed [31:0]  value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sidi_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

@@ src/sidi_dabble_stage.sv @@
// ----------------------------------------------------------------------------
// sidi_dabble_stage: one binary-to-BCD pipeline stage
// Shifts a slice of the binary magnitude into the BCD digits, with add-3
// correction, and registers the result behind a valid/ready handshake.
// ----------------------------------------------------------------------------
module sidi_dabble_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          valid_i,
  output logic          ready_o,
  input  sidi_pkg::dab_t data_i,
  output logic          valid_o,
  input  logic          ready_i,
  output sidi_pkg::dab_t data_o
);
  import sidi_pkg::*;

  logic valid_r;
  dab_t data_r;
  dab_t data_nxt;

  always_comb begin
    logic [BcdW-1:0]   bcd;
    logic [ValueW-1:0] bin;
    bcd = data_i.bcd;
    bin = data_i.bin;
    for (int s = 0; s < StepsPerStage; s++) begin
      for (int d = 0; d < NumDigits; d++) begin
        if (bcd[4*d +: 4] >= 4'd5) begin
          bcd[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
        end
      end
      {bcd, bin} = {bcd[BcdW-2:0], bin, 1'b0};
    end
    data_nxt.neg = data_i.neg;
    data_nxt.bin = bin;
    data_nxt.bcd = bcd;
  end

  assign ready_o = !valid_r || ready_i;
  assign valid_o = valid_r;
  assign data_o  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_i && ready_o) begin
      data_r <= data_nxt;
    end
  end

endmodule

@@ src/signed_int_to_decimal_ascii_unit.sv @@
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit: signed 32-bit integer to decimal text
// Converts each input word to its ASCII decimal text, one character per
// output word, most significant first.
// ----------------------------------------------------------------------------
// Usage:
//   in_if  : one signed 32-bit value per word (valid/ready).
//   out_if : one ASCII character per word; last marks the final character.
//   A negative value emits '-' first; zero emits "0"; no leading zeros.
// Pipeline: an input word passes one magnitude stage, four 8-bit BCD stages
//   and one load register before its first character is valid.
// Flow: the character serializer paces the unit; a value's text is 1 to 11
//   characters long and the next value waits for the last of them. The BCD
//   pipeline holds up to five values behind it, so a new value is loaded
//   at the edge that takes the previous one's last character, with no gap.
// Reset: synchronous, active low; all stages and the serializer empty.
// Stall: out_if.ready low holds the current character; the pipeline fills
//   and then drops in_if.ready. Nothing is lost or repeated.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_unit (
  input  logic clk,
  input  logic rst_n,
  sidi_in_if.sink    in_if,
  sidi_out_if.source out_if
);
  import sidi_pkg::*;

  // magnitude stage
  logic s0_valid_r;
  dab_t s0_data_r;
  logic s0_ready;

  logic [NumStages:0] st_valid;
  logic [NumStages:0] st_ready;
  dab_t               st_data [NumStages+1];

  // serializer
  logic                busy_r;
  logic                sign_r;
  logic [BcdW-1:0]     bcd_r;
  logic [IdxW-1:0]     idx_r;
  logic                ser_ready;
  logic                ser_load;
  logic                out_fire;
  logic [IdxW-1:0]     top_idx;
  logic [ValueW-1:0]   raw;

  assign raw      = in_if.value;
  assign s0_ready = !s0_valid_r || st_ready[0];
  assign in_if.ready = s0_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (s0_ready) begin
      s0_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && s0_ready) begin
      s0_data_r.neg <= raw[ValueW-1];
      s0_data_r.bin <= raw[ValueW-1] ? (~raw + 1'b1) : raw;
      s0_data_r.bcd <= '0;
    end
  end

  assign st_valid[0] = s0_valid_r;
  assign st_data[0]  = s0_data_r;

  for (genvar k = 0; k < NumStages; k++) begin : g_stage
    sidi_dabble_stage u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (st_valid[k]),
      .ready_o (st_ready[k]),
      .data_i  (st_data[k]),
      .valid_o (st_valid[k+1]),
      .ready_i (st_ready[k+1]),
      .data_o  (st_data[k+1])
    );
  end

  // highest nonzero digit, zero gives digit 0
  always_comb begin
    top_idx = '0;
    for (int i = 0; i < NumDigits; i++) begin
      if (st_data[NumStages].bcd[4*i +: 4] != 4'd0) begin
        top_idx = IdxW'(i);
      end
    end
  end

  assign out_fire  = out_if.valid && out_if.ready;
  assign ser_ready = !busy_r || (out_fire && out_if.last);
  assign ser_load  = st_valid[NumStages] && ser_ready;
  assign st_ready[NumStages] = ser_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      sign_r <= 1'b0;
      idx_r  <= '0;
    end else if (ser_load) begin
      busy_r <= 1'b1;
      sign_r <= st_data[NumStages].neg;
      idx_r  <= top_idx;
    end else if (out_fire) begin
      if (sign_r) begin
        sign_r <= 1'b0;
      end else if (idx_r == '0) begin
        busy_r <= 1'b0;
      end else begin
        idx_r <= idx_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ser_load) begin
      bcd_r <= st_data[NumStages].bcd;
    end
  end

  assign out_if.valid     = busy_r;
  assign out_if.character = sign_r ? CharMinus
                                   : (CharZero | CharW'(bcd_r[4*idx_r +: 4]));
  assign out_if.last      = !sign_r && (idx_r == '0);

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (idx_r < IdxW'(NumDigits)))
    else $error("digit index out of range");

  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && out_if.last && !ser_load |=> !busy_r)
    else $error("serializer busy after last character");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    st_valid[NumStages] && !ser_ready |=>
      st_valid[NumStages] && $stable(st_data[NumStages]))
    else $error("converted value lost while serializer busy");

endmodule
